// ----- sv/sgcc_pkg.sv -----
`default_nettype none

package sgcc_pkg;

    // Field widths
    localparam int PTS_W   = 11;
    localparam int COORD_W = 10;
    localparam int ID_W    = 30;
    localparam int IDX_W   = 32;
    localparam int OFF_W   = 34;
    localparam int PLANE_W = 22;
    localparam int ROWP_W  = 21;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_POINTS_X  = 2'd0,
        CFG_POINTS_Y  = 2'd1,
        CFG_POINTS_Z  = 2'd2,
        CFG_GRID_KIND = 2'd3
    } cfg_index_t;

    // Cell shape codes
    localparam logic [1:0] SHAPE_VOXEL = 2'd0;
    localparam logic [1:0] SHAPE_HEX   = 2'd1;
    localparam logic [1:0] SHAPE_PIXEL = 2'd2;
    localparam logic [1:0] SHAPE_QUAD  = 2'd3;

    // Reset values of the configuration
    localparam logic [PTS_W-1:0] PTS_RESET  = 11'd2;
    localparam logic             KIND_RESET = 1'b0;

    typedef struct packed {
        logic [PTS_W-1:0] points_x;
        logic [PTS_W-1:0] points_y;
        logic [PTS_W-1:0] points_z;
        logic             grid_kind;
    } cfg_t;

    // Stage 1: renamed axes, range check
    typedef struct packed {
        logic [COORD_W-1:0] i;
        logic [COORD_W-1:0] j;
        logic [COORD_W-1:0] k;
        logic [PTS_W-1:0]   ex;
        logic [PTS_W-1:0]   ey;
        logic [PTS_W-1:0]   row;
        logic               ok;
        logic               d3;
        logic               kind;
    } s1_t;

    // Stage 2: first products
    typedef struct packed {
        logic [COORD_W-1:0] i;
        logic [COORD_W-1:0] j;
        logic [COORD_W-1:0] k;
        logic [PTS_W-1:0]   ex;
        logic [PTS_W-1:0]   row;
        logic [PLANE_W-1:0] plane;
        logic [ROWP_W-1:0]  ky;
        logic [ROWP_W-1:0]  y0;
        logic               ok;
        logic               d3;
        logic               kind;
    } s2_t;

    // Stage 3: plane offsets, row offsets
    typedef struct packed {
        logic [COORD_W-1:0] i;
        logic [PTS_W-1:0]   ex;
        logic [ID_W-1:0]    z0;
        logic [ID_W-1:0]    z1;
        logic [PLANE_W-1:0] kyj;
        logic [PLANE_W-1:0] y0i;
        logic [PLANE_W-1:0] y1i;
        logic               ok;
        logic               d3;
        logic               kind;
    } s3_t;

    // Stage 4: corner bases and linear index
    typedef struct packed {
        logic [ID_W-1:0]  a;
        logic [ID_W-1:0]  b;
        logic [ID_W-1:0]  c;
        logic [ID_W-1:0]  e;
        logic [IDX_W-1:0] idx;
        logic             ok;
        logic             d3;
        logic             kind;
    } s4_t;

endpackage

`default_nettype wire

// ----- sv/sgcc_cfg_regs.sv -----
`default_nettype none

module sgcc_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [sgcc_pkg::PTS_W-1:0]   cfg_data,
    output sgcc_pkg::cfg_t                    cfg
);

    sgcc_pkg::cfg_t cfg_reg;
    sgcc_pkg::cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (sgcc_pkg::cfg_index_t'(cfg_index))
                sgcc_pkg::CFG_POINTS_X:  cfg_next.points_x  = cfg_data;
                sgcc_pkg::CFG_POINTS_Y:  cfg_next.points_y  = cfg_data;
                sgcc_pkg::CFG_POINTS_Z:  cfg_next.points_z  = cfg_data;
                sgcc_pkg::CFG_GRID_KIND: cfg_next.grid_kind = cfg_data[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.points_x  <= sgcc_pkg::PTS_RESET;
            cfg_reg.points_y  <= sgcc_pkg::PTS_RESET;
            cfg_reg.points_z  <= sgcc_pkg::PTS_RESET;
            cfg_reg.grid_kind <= sgcc_pkg::KIND_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- sv/sgcc_geom.sv -----
`default_nettype none

module sgcc_geom #(
    parameter int MAX_POINTS_PER_AXIS = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_vld,
    input  wire logic [sgcc_pkg::COORD_W-1:0]   cell_x,
    input  wire logic [sgcc_pkg::COORD_W-1:0]   cell_y,
    input  wire logic [sgcc_pkg::COORD_W-1:0]   cell_z,
    input  wire sgcc_pkg::cfg_t                 cfg,
    output logic                                vld,
    output sgcc_pkg::s1_t                       s1
);

    // Largest point count an 11-bit register can hold
    localparam int PTS_MAX_REG = (1 << sgcc_pkg::PTS_W) - 1;
    localparam int CAP_INT     = (MAX_POINTS_PER_AXIS > PTS_MAX_REG) ?
                                 PTS_MAX_REG : MAX_POINTS_PER_AXIS;
    localparam logic [sgcc_pkg::PTS_W-1:0] PTS_CAP = sgcc_pkg::PTS_W'(CAP_INT);

    // Cells along an axis, point count clamped to one..cap
    function automatic logic [sgcc_pkg::PTS_W-1:0] cells_on(
        input logic [sgcc_pkg::PTS_W-1:0] pts
    );
        logic [sgcc_pkg::PTS_W-1:0] c;
        c = pts;
        if (c == '0)
            c = sgcc_pkg::PTS_W'(1);
        if (c > PTS_CAP)
            c = PTS_CAP;
        return c - sgcc_pkg::PTS_W'(1);
    endfunction

    logic [sgcc_pkg::PTS_W-1:0] nx;
    logic [sgcc_pkg::PTS_W-1:0] ny;
    logic [sgcc_pkg::PTS_W-1:0] nz;
    logic [sgcc_pkg::PTS_W-1:0] ix;
    logic [sgcc_pkg::PTS_W-1:0] jy;
    logic [sgcc_pkg::PTS_W-1:0] kz;
    logic                       d3;
    sgcc_pkg::s1_t              s1_next;
    sgcc_pkg::s1_t              s1_reg;
    logic                       vld_reg;

    assign nx = cells_on(cfg.points_x);
    assign ny = cells_on(cfg.points_y);
    assign nz = cells_on(cfg.points_z);
    assign d3 = (nx != '0) && (ny != '0) && (nz != '0);
    assign ix = {1'b0, cell_x};
    assign jy = {1'b0, cell_y};
    assign kz = {1'b0, cell_z};

    // Rename the axes and check the range
    always_comb
    begin
        s1_next.i    = cell_x;
        s1_next.j    = cell_y;
        s1_next.kind = cfg.grid_kind;
        s1_next.d3   = d3;
        s1_next.ex   = nx;
        s1_next.ey   = ny;
        s1_next.k    = '0;
        if (d3)
        begin
            s1_next.k = cell_z;
        end
        else
        begin
            priority if (nz == '0)
            begin
                s1_next.ex = nx;
                s1_next.ey = ny;
            end
            else if (ny == '0)
            begin
                s1_next.ex = nx;
                s1_next.ey = nz;
            end
            else
            begin
                s1_next.ex = ny;
                s1_next.ey = nz;
            end
        end
        s1_next.ok  = (ix < s1_next.ex) && (jy < s1_next.ey) && (!d3 || (kz < nz));
        s1_next.row = s1_next.ex + sgcc_pkg::PTS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
            s1_reg <= s1_next;
    end

    assign vld = vld_reg;
    assign s1  = s1_reg;

endmodule

`default_nettype wire

// ----- sv/sgcc_addr.sv -----
`default_nettype none

module sgcc_addr (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_vld,
    input  wire sgcc_pkg::s1_t  s1,
    output logic                vld,
    output sgcc_pkg::s4_t       s4
);

    localparam int PW = sgcc_pkg::PLANE_W;
    localparam int RW = sgcc_pkg::ROWP_W;
    localparam int IW = sgcc_pkg::ID_W;
    localparam int XW = sgcc_pkg::IDX_W;

    logic          v2_reg;
    logic          v3_reg;
    logic          v4_reg;
    sgcc_pkg::s2_t s2_next;
    sgcc_pkg::s2_t s2_reg;
    sgcc_pkg::s3_t s3_next;
    sgcc_pkg::s3_t s3_reg;
    sgcc_pkg::s4_t s4_next;
    sgcc_pkg::s4_t s4_reg;

    // Stage 2: plane size, k*ey, j*row
    always_comb
    begin
        s2_next.i     = s1.i;
        s2_next.j     = s1.j;
        s2_next.k     = s1.k;
        s2_next.ex    = s1.ex;
        s2_next.row   = s1.row;
        s2_next.ok    = s1.ok;
        s2_next.d3    = s1.d3;
        s2_next.kind  = s1.kind;
        s2_next.plane = PW'(s1.row) * PW'(s1.ey + sgcc_pkg::PTS_W'(1));
        s2_next.ky    = RW'(s1.k) * RW'(s1.ey);
        s2_next.y0    = RW'(s1.j) * RW'(s1.row);
    end

    // Stage 3: plane offsets, row offsets plus i
    always_comb
    begin
        s3_next.i    = s2_reg.i;
        s3_next.ex   = s2_reg.ex;
        s3_next.ok   = s2_reg.ok;
        s3_next.d3   = s2_reg.d3;
        s3_next.kind = s2_reg.kind;
        s3_next.z0   = IW'(s2_reg.k) * IW'(s2_reg.plane);
        s3_next.z1   = IW'({1'b0, s2_reg.k} + 11'd1) * IW'(s2_reg.plane);
        s3_next.kyj  = PW'(s2_reg.ky) + PW'(s2_reg.j);
        s3_next.y0i  = PW'(s2_reg.y0) + PW'(s2_reg.i);
        s3_next.y1i  = PW'(s2_reg.y0) + PW'(s2_reg.row) + PW'(s2_reg.i);
    end

    // Stage 4: corner bases and linear index
    always_comb
    begin
        s4_next.ok   = s3_reg.ok;
        s4_next.d3   = s3_reg.d3;
        s4_next.kind = s3_reg.kind;
        s4_next.a    = s3_reg.z0 + IW'(s3_reg.y0i);
        s4_next.b    = s3_reg.z0 + IW'(s3_reg.y1i);
        s4_next.c    = s3_reg.z1 + IW'(s3_reg.y0i);
        s4_next.e    = s3_reg.z1 + IW'(s3_reg.y1i);
        s4_next.idx  = XW'(33'(s3_reg.kyj) * 33'(s3_reg.ex) + 33'(s3_reg.i));
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= in_vld;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Advance payload with its valid bit
    always_ff @(posedge clk)
    begin
        if (in_vld)
            s2_reg <= s2_next;
        if (v2_reg)
            s3_reg <= s3_next;
        if (v3_reg)
            s4_reg <= s4_next;
    end

    assign vld = v4_reg;
    assign s4  = s4_reg;

endmodule

`default_nettype wire

// ----- sv/structured_grid_cell_corner_ids_core.sv -----
// Corner point ids of one structured-grid cell. A cell is taken on every
// clock edge where start is high; busy is always low, so one cell per clock
// is sustained. Each result appears with done high for exactly one cycle,
// in the order the cells were taken; the receiver cannot hold results off.
// The pipeline has five register stages: axis renaming and range check, the
// products row*(ey+1), k*ey and j*row, the plane offsets k*plane and
// (k+1)*plane, the corner sums with the linear index multiply, and the
// output register. Configuration writes take effect on the next cycle and
// must only be made with no cell in flight.
`default_nettype none

module structured_grid_cell_corner_ids_core #(
    parameter int MAX_POINTS_PER_AXIS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [9:0]  cell_x,
    input  wire logic [9:0]  cell_y,
    input  wire logic [9:0]  cell_z,
    output logic             done,
    output logic [29:0]      corner0,
    output logic [29:0]      corner1,
    output logic [29:0]      corner2,
    output logic [29:0]      corner3,
    output logic [29:0]      corner4,
    output logic [29:0]      corner5,
    output logic [29:0]      corner6,
    output logic [29:0]      corner7,
    output logic [1:0]       shape_code,
    output logic [29:0]      linear_index,
    output logic [33:0]      end_offset,
    output logic             in_range
);

    localparam int IW = sgcc_pkg::ID_W;
    localparam int OW = sgcc_pkg::OFF_W;

    sgcc_pkg::cfg_t    cfg;
    sgcc_pkg::s1_t     s1;
    sgcc_pkg::s4_t     s4;
    logic              v1;
    logic              v4;
    logic              accept;

    logic              done_reg;
    logic [IW-1:0]     corner_reg [8];
    logic [IW-1:0]     corner_next [8];
    logic [1:0]        shape_reg;
    logic [1:0]        shape_next;
    logic [IW-1:0]     index_reg;
    logic [IW-1:0]     index_next;
    logic [OW-1:0]     offset_reg;
    logic [OW-1:0]     offset_next;
    logic              range_reg;
    logic              range_next;
    logic [32:0]       idx_plus;

    // The pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    sgcc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sgcc_geom #(
        .MAX_POINTS_PER_AXIS (MAX_POINTS_PER_AXIS)
    ) u_geom (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (accept),
        .cell_x (cell_x),
        .cell_y (cell_y),
        .cell_z (cell_z),
        .cfg    (cfg),
        .vld    (v1),
        .s1     (s1)
    );

    sgcc_addr u_addr (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (v1),
        .s1     (s1),
        .vld    (v4),
        .s4     (s4)
    );

    assign idx_plus = {1'b0, s4.idx} + 33'd1;

    // Order the corners, pick the shape, zero an out-of-range cell
    always_comb
    begin
        corner_next[0] = s4.a;
        corner_next[1] = s4.a + IW'(1);
        corner_next[2] = s4.kind ? s4.b + IW'(1) : s4.b;
        corner_next[3] = s4.kind ? s4.b : s4.b + IW'(1);
        corner_next[4] = s4.c;
        corner_next[5] = s4.c + IW'(1);
        corner_next[6] = s4.kind ? s4.e + IW'(1) : s4.e;
        corner_next[7] = s4.kind ? s4.e : s4.e + IW'(1);
        index_next     = s4.idx[IW-1:0];
        range_next     = s4.ok;
        if (s4.d3)
        begin
            shape_next  = s4.kind ? sgcc_pkg::SHAPE_HEX : sgcc_pkg::SHAPE_VOXEL;
            offset_next = OW'(idx_plus) << 3;
        end
        else
        begin
            shape_next  = s4.kind ? sgcc_pkg::SHAPE_QUAD : sgcc_pkg::SHAPE_PIXEL;
            offset_next = OW'(idx_plus) << 2;
            for (int q = 4; q < 8; q++)
                corner_next[q] = '0;
        end
        if (!s4.ok)
        begin
            for (int q = 0; q < 8; q++)
                corner_next[q] = '0;
            shape_next  = '0;
            index_next  = '0;
            offset_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v4;
    end

    // Hold the result for its one-cycle transfer
    always_ff @(posedge clk)
    begin
        if (v4)
        begin
            corner_reg <= corner_next;
            shape_reg  <= shape_next;
            index_reg  <= index_next;
            offset_reg <= offset_next;
            range_reg  <= range_next;
        end
    end

    assign done         = done_reg;
    assign corner0      = corner_reg[0];
    assign corner1      = corner_reg[1];
    assign corner2      = corner_reg[2];
    assign corner3      = corner_reg[3];
    assign corner4      = corner_reg[4];
    assign corner5      = corner_reg[5];
    assign corner6      = corner_reg[6];
    assign corner7      = corner_reg[7];
    assign shape_code   = shape_reg;
    assign linear_index = index_reg;
    assign end_offset   = offset_reg;
    assign in_range     = range_reg;

endmodule

`default_nettype wire

// ----- test/structured_grid_cell_corner_ids_core_tb.sv -----
module structured_grid_cell_corner_ids_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PTS = 1024;
    localparam int LATENCY = 5;
    localparam int LIMIT   = 200000;

    typedef struct packed {
        logic [7:0][sgcc_pkg::ID_W-1:0] corner;
        logic [1:0]                     shape;
        logic [sgcc_pkg::ID_W-1:0]      index;
        logic [sgcc_pkg::OFF_W-1:0]     offset;
        logic                           in_range;
    } cell_result_t;

    // Grid configuration mirror, corner id prediction and result checking
    class corner_id_scoreboard;
        sgcc_pkg::cfg_t grid;
        cell_result_t   expected_corners[$];
        int             errors;

        function new();
            grid.points_x  = sgcc_pkg::PTS_RESET;
            grid.points_y  = sgcc_pkg::PTS_RESET;
            grid.points_z  = sgcc_pkg::PTS_RESET;
            grid.grid_kind = sgcc_pkg::KIND_RESET;
            errors = 0;
        endfunction

        function void write_reg(sgcc_pkg::cfg_index_t idx,
                                logic [sgcc_pkg::PTS_W-1:0] data);
            case (idx)
                sgcc_pkg::CFG_POINTS_X:  grid.points_x  = data;
                sgcc_pkg::CFG_POINTS_Y:  grid.points_y  = data;
                sgcc_pkg::CFG_POINTS_Z:  grid.points_z  = data;
                sgcc_pkg::CFG_GRID_KIND: grid.grid_kind = data[0];
                default: ;
            endcase
        endfunction

        // Cells along one axis, with the point count clamped to 1..MAX_PTS
        function longint unsigned axis_cells(logic [sgcc_pkg::PTS_W-1:0] pts);
            if (pts == 0)
                return 0;
            if (pts > MAX_PTS)
                return MAX_PTS - 1;
            return pts - 1;
        endfunction

        // Cell extents after axis renaming; ez is zero for a 2D grid
        function void grid_spans(output longint unsigned ex, ey, ez);
            longint unsigned nx, ny, nz;
            nx = axis_cells(grid.points_x);
            ny = axis_cells(grid.points_y);
            nz = axis_cells(grid.points_z);
            ex = nx;
            ey = ny;
            ez = 0;
            if (nx != 0 && ny != 0 && nz != 0)
                ez = nz;
            else if (nz == 0)
                ez = 0;
            else if (ny == 0)
                ey = nz;
            else
            begin
                ex = ny;
                ey = nz;
            end
        endfunction

        function cell_result_t predict_corners(logic [sgcc_pkg::COORD_W-1:0] x, y, z);
            longint unsigned ex, ey, ez, row, plane, z0, z1, y0, y1, lin, count;
            cell_result_t r;
            r = '0;
            grid_spans(ex, ey, ez);
            if (ez != 0)
            begin
                if (x >= ex || y >= ey || z >= ez)
                    return r;
                row   = ex + 1;
                plane = row * (ey + 1);
                z0 = z * plane;
                z1 = (z + 1) * plane;
                y0 = y * row;
                y1 = (y + 1) * row;
                r.corner[0] = sgcc_pkg::ID_W'(z0 + y0 + x);
                r.corner[1] = sgcc_pkg::ID_W'(z0 + y0 + x + 1);
                r.corner[4] = sgcc_pkg::ID_W'(z1 + y0 + x);
                r.corner[5] = sgcc_pkg::ID_W'(z1 + y0 + x + 1);
                // curvilinear order walks the far row backwards
                if (grid.grid_kind == 1'b0)
                begin
                    r.corner[2] = sgcc_pkg::ID_W'(z0 + y1 + x);
                    r.corner[3] = sgcc_pkg::ID_W'(z0 + y1 + x + 1);
                    r.corner[6] = sgcc_pkg::ID_W'(z1 + y1 + x);
                    r.corner[7] = sgcc_pkg::ID_W'(z1 + y1 + x + 1);
                    r.shape = sgcc_pkg::SHAPE_VOXEL;
                end
                else
                begin
                    r.corner[2] = sgcc_pkg::ID_W'(z0 + y1 + x + 1);
                    r.corner[3] = sgcc_pkg::ID_W'(z0 + y1 + x);
                    r.corner[6] = sgcc_pkg::ID_W'(z1 + y1 + x + 1);
                    r.corner[7] = sgcc_pkg::ID_W'(z1 + y1 + x);
                    r.shape = sgcc_pkg::SHAPE_HEX;
                end
                lin   = (z * ey + y) * ex + x;
                count = 8;
            end
            else
            begin
                // an empty 2D grid fails this too
                if (x >= ex || y >= ey)
                    return r;
                row = ex + 1;
                y0  = y * row;
                y1  = (y + 1) * row;
                r.corner[0] = sgcc_pkg::ID_W'(y0 + x);
                r.corner[1] = sgcc_pkg::ID_W'(y0 + x + 1);
                if (grid.grid_kind == 1'b0)
                begin
                    r.corner[2] = sgcc_pkg::ID_W'(y1 + x);
                    r.corner[3] = sgcc_pkg::ID_W'(y1 + x + 1);
                    r.shape = sgcc_pkg::SHAPE_PIXEL;
                end
                else
                begin
                    r.corner[2] = sgcc_pkg::ID_W'(y1 + x + 1);
                    r.corner[3] = sgcc_pkg::ID_W'(y1 + x);
                    r.shape = sgcc_pkg::SHAPE_QUAD;
                end
                lin   = y * ex + x;
                count = 4;
            end
            r.index    = sgcc_pkg::ID_W'(lin);
            r.offset   = sgcc_pkg::OFF_W'(count * (lin + 1));
            r.in_range = 1'b1;
            return r;
        endfunction

        function void note_transfer(logic [sgcc_pkg::COORD_W-1:0] x, y, z);
            expected_corners.push_back(predict_corners(x, y, z));
        endfunction

        function void compare_field(string name,
                                    logic [sgcc_pkg::OFF_W-1:0] want,
                                    logic [sgcc_pkg::OFF_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch on %s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        function void check_result(cell_result_t got);
            cell_result_t want;
            if (expected_corners.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result strobe with no transfer outstanding");
                return;
            end
            want = expected_corners.pop_front();
            for (int q = 0; q < 8; q++)
                compare_field($sformatf("corner%0d", q),
                              sgcc_pkg::OFF_W'(want.corner[q]),
                              sgcc_pkg::OFF_W'(got.corner[q]));
            compare_field("shape_code", sgcc_pkg::OFF_W'(want.shape),
                          sgcc_pkg::OFF_W'(got.shape));
            compare_field("linear_index", sgcc_pkg::OFF_W'(want.index),
                          sgcc_pkg::OFF_W'(got.index));
            compare_field("end_offset", want.offset, got.offset);
            compare_field("in_range", sgcc_pkg::OFF_W'(want.in_range),
                          sgcc_pkg::OFF_W'(got.in_range));
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    sgcc_pkg::cfg_index_t         cfg_index;
    logic [sgcc_pkg::PTS_W-1:0]   cfg_data;
    logic                         start;
    logic                         busy;
    logic [sgcc_pkg::COORD_W-1:0] cell_x;
    logic [sgcc_pkg::COORD_W-1:0] cell_y;
    logic [sgcc_pkg::COORD_W-1:0] cell_z;
    logic                         done;
    logic [sgcc_pkg::ID_W-1:0]    corner0, corner1, corner2, corner3;
    logic [sgcc_pkg::ID_W-1:0]    corner4, corner5, corner6, corner7;
    logic [1:0]                   shape_code;
    logic [sgcc_pkg::ID_W-1:0]    linear_index;
    logic [sgcc_pkg::OFF_W-1:0]   end_offset;
    logic                         in_range;

    corner_id_scoreboard sb = new();
    int unsigned         cycles = 0;

    structured_grid_cell_corner_ids_core #(
        .MAX_POINTS_PER_AXIS(MAX_PTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .start(start),
        .busy(busy),
        .cell_x(cell_x),
        .cell_y(cell_y),
        .cell_z(cell_z),
        .done(done),
        .corner0(corner0),
        .corner1(corner1),
        .corner2(corner2),
        .corner3(corner3),
        .corner4(corner4),
        .corner5(corner5),
        .corner6(corner6),
        .corner7(corner7),
        .shape_code(shape_code),
        .linear_index(linear_index),
        .end_offset(end_offset),
        .in_range(in_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watch register writes, transfers and result strobes
    always @(posedge clk)
    begin
        cell_result_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got.corner   = {corner7, corner6, corner5, corner4,
                                corner3, corner2, corner1, corner0};
                got.shape    = shape_code;
                got.index    = linear_index;
                got.offset   = end_offset;
                got.in_range = in_range;
                sb.check_result(got);
            end
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (start && !busy)
                sb.note_transfer(cell_x, cell_y, cell_z);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("structured_grid_cell_corner_ids_core verification failed");
            $finish;
        end
    end

    // Hold one cell on the inputs until it transfers
    task automatic drive_cell(input logic [sgcc_pkg::COORD_W-1:0] x, y, z);
        @(negedge clk);
        start  <= 1'b1;
        cell_x <= x;
        cell_y <= y;
        cell_z <= z;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drop start with junk on the coordinates
    task automatic idle(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start  <= 1'b0;
            cell_x <= sgcc_pkg::COORD_W'($urandom);
            cell_y <= sgcc_pkg::COORD_W'($urandom);
            cell_z <= sgcc_pkg::COORD_W'($urandom);
        end
    endtask

    task automatic write_reg(input sgcc_pkg::cfg_index_t idx,
                             input logic [sgcc_pkg::PTS_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    // Drain the pipeline, then load a new grid
    task automatic write_grid(input logic [sgcc_pkg::PTS_W-1:0] px, py, pz,
                              input logic kind);
        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_corners.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
        write_reg(sgcc_pkg::CFG_POINTS_X, px);
        write_reg(sgcc_pkg::CFG_POINTS_Y, py);
        write_reg(sgcc_pkg::CFG_POINTS_Z, pz);
        write_reg(sgcc_pkg::CFG_GRID_KIND, sgcc_pkg::PTS_W'(kind));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly inside the grid, with edges, one-past-the-edge and full-range noise
    function automatic logic [sgcc_pkg::COORD_W-1:0] pick_coord(longint unsigned extent);
        int unsigned roll;
        roll = $urandom_range(0, 39);
        if (extent == 0 || roll < 2)
            return sgcc_pkg::COORD_W'($urandom);
        if (roll == 2)
            return sgcc_pkg::COORD_W'(extent);
        if (roll == 3)
            return sgcc_pkg::COORD_W'(extent - 1);
        return sgcc_pkg::COORD_W'($urandom_range(0, int'(extent - 1)));
    endfunction

    function automatic logic [sgcc_pkg::PTS_W-1:0] pick_points();
        case ($urandom_range(0, 9))
            0: return sgcc_pkg::PTS_W'(0);
            1: return sgcc_pkg::PTS_W'(1);
            2: return sgcc_pkg::PTS_W'(MAX_PTS);
            3: return sgcc_pkg::PTS_W'($urandom_range(MAX_PTS + 1, 2047));
            default: return sgcc_pkg::PTS_W'($urandom_range(2, 40));
        endcase
    endfunction

    // Random cells in bursts with random gaps, sometimes back to back
    task automatic send_cells(input int n);
        int left;
        int burst;
        longint unsigned ex, ey, ez;
        left = n;
        sb.grid_spans(ex, ey, ez);
        while (left > 0)
        begin
            burst = $urandom_range(1, 16);
            if (burst > left)
                burst = left;
            repeat (burst)
                drive_cell(pick_coord(ex), pick_coord(ey), pick_coord(ez));
            left -= burst;
            if ($urandom_range(0, 3) != 0)
                idle($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = sgcc_pkg::CFG_POINTS_X;
        cfg_data  = '0;
        start     = 1'b0;
        cell_x    = '0;
        cell_y    = '0;
        cell_z    = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset grid: a single voxel, every neighbor out of range
        drive_cell(0, 0, 0);
        drive_cell(1, 0, 0);
        drive_cell(0, 1, 0);
        drive_cell(0, 0, 1);
        drive_cell(1023, 1023, 1023);

        // Largest grid, hexahedron order, far corners
        write_grid(MAX_PTS, MAX_PTS, MAX_PTS, 1'b1);
        drive_cell(0, 0, 0);
        drive_cell(1022, 1022, 1022);
        drive_cell(1023, 1022, 1022);
        drive_cell(1022, 1023, 0);
        drive_cell(0, 0, 1023);
        drive_cell(511, 300, 700);

        // Flat in z: pixels, z ignored
        write_grid(9, 5, 1, 1'b0);
        drive_cell(7, 3, 1023);
        drive_cell(8, 3, 0);
        drive_cell(0, 0, 0);

        // Flat in y: z becomes the second axis
        write_grid(6, 1, 4, 1'b1);
        drive_cell(4, 2, 5);
        drive_cell(4, 3, 0);

        // Flat in x: y and z shift down
        write_grid(1, 7, 3, 1'b0);
        drive_cell(5, 1, 0);
        drive_cell(6, 1, 0);

        // No cells at all
        write_grid(1, 1, 1, 1'b1);
        drive_cell(0, 0, 0);

        // Zero count and counts above the maximum
        write_grid(0, 2047, 1500, 1'b1);
        drive_cell(1022, 1022, 0);
        drive_cell(1023, 0, 0);
        write_grid(2047, 2047, 2047, 1'b0);
        drive_cell(1022, 1022, 1022);
        drive_cell(0, 0, 0);

        // Random traffic over a series of grids
        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0: write_grid(5, 4, 3, 1'b0);
                1: write_grid(5, 4, 3, 1'b1);
                2: write_grid(MAX_PTS, MAX_PTS, MAX_PTS, 1'b0);
                3: write_grid(12, 9, 1, 1'b1);
                4: write_grid(8, 1, 6, 1'b0);
                5: write_grid(1, 10, 7, 1'b1);
                6: write_grid(2047, 0, 3, 1'b0);
                default: write_grid(pick_points(), pick_points(), pick_points(),
                                    1'($urandom));
            endcase
            send_cells(75);
        end

        // Drain and settle
        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_corners.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);

        if (sb.errors == 0 && sb.expected_corners.size() == 0)
            $display("structured_grid_cell_corner_ids_core verification clean");
        else
            $display("structured_grid_cell_corner_ids_core verification failed");
        $finish;
    end

endmodule
